// ----- rtl/core/dqso_pkg.sv -----
// Shared types and constants for the dual quadrature speed odometer.
// No dependencies; every other file of the block refers to this package.
`default_nettype none

package dqso_pkg;

  localparam int COUNT_BITS_DEF = 16;

  localparam int SCALE_W   = 24;
  localparam int INV_W     = 2;
  localparam int SPEED_W   = 40;
  localparam int DIST_W    = 48;
  localparam int EDGES_W   = 32;
  localparam int REQ_W     = 2;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DAT_W = 24;

  typedef enum logic [REQ_W-1:0] {
    REQ_EDGE  = 2'd0,
    REQ_TICK  = 2'd1,
    REQ_CLEAR = 2'd2
  } req_t;

  localparam logic MOTOR_LEFT  = 1'b0;
  localparam logic MOTOR_RIGHT = 1'b1;
  localparam logic CHAN_A      = 1'b0;

  localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE      = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISTANCE_SCALE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION_INVERT = 8'd2;

  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST    = 24'd63350;
  localparam logic [SCALE_W-1:0] DISTANCE_SCALE_RST = 24'd634;
  localparam logic [INV_W-1:0]   DIR_INVERT_RST     = 2'd2;

  typedef struct packed {
    logic [SCALE_W-1:0] speed_scale;
    logic [SCALE_W-1:0] distance_scale;
    logic [INV_W-1:0]   direction_invert;
  } cfg_regs_t;

  // Per-wheel command for the cycle in which an item is processed.
  typedef struct packed {
    logic edge_hit;
    logic tick;
    logic clear;
    logic dir_up;
  } wheel_ctrl_t;

endpackage

`default_nettype wire

// ----- rtl/core/dqso_in_if.sv -----
// Input channel interface: valid/ready handshake with the request fields.
// Field widths come from dqso_pkg.
`default_nettype none

interface dqso_in_if;
  logic                         valid;
  logic                         ready;
  logic [dqso_pkg::REQ_W-1:0]   req_type;
  logic                         motor_sel;
  logic                         edge_channel;
  logic                         level_a;
  logic                         level_b;

  modport source (output valid, req_type, motor_sel, edge_channel, level_a, level_b,
                  input ready);
  modport sink   (input valid, req_type, motor_sel, edge_channel, level_a, level_b,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqso_out_if.sv -----
// Result channel interface: valid/ready handshake with speeds, distances and edge totals.
// Field widths come from dqso_pkg.
`default_nettype none

interface dqso_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [dqso_pkg::SPEED_W-1:0] speed_left;
  logic signed [dqso_pkg::SPEED_W-1:0] speed_right;
  logic signed [dqso_pkg::DIST_W-1:0]  trip_left;
  logic signed [dqso_pkg::DIST_W-1:0]  trip_right;
  logic signed [dqso_pkg::DIST_W-1:0]  total_left;
  logic signed [dqso_pkg::DIST_W-1:0]  total_right;
  logic        [dqso_pkg::EDGES_W-1:0] edges_left;
  logic        [dqso_pkg::EDGES_W-1:0] edges_right;

  modport source (output valid, speed_left, speed_right, trip_left, trip_right,
                  total_left, total_right, edges_left, edges_right,
                  input ready);
  modport sink   (input valid, speed_left, speed_right, trip_left, trip_right,
                  total_left, total_right, edges_left, edges_right,
                  output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqso_cfg_if.sv -----
// Configuration write channel interface: valid/ready with register index and data.
// Field widths come from dqso_pkg.
`default_nettype none

interface dqso_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [dqso_pkg::CFG_IDX_W-1:0] addr;
  logic [dqso_pkg::CFG_DAT_W-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink   (input valid, addr, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/dqso_cfg.sv -----
// Configuration register file: speed scale, distance scale, direction invert.
// Depends on dqso_pkg and dqso_cfg_if.
`default_nettype none

module dqso_cfg (
  input  logic                clk,
  input  logic                rst_n,
  dqso_cfg_if.sink            cfg_ch,
  output dqso_pkg::cfg_regs_t regs
);

  dqso_pkg::cfg_regs_t regs_r;
  dqso_pkg::cfg_regs_t regs_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.addr)
        dqso_pkg::CFG_SPEED_SCALE:      regs_nxt.speed_scale = cfg_ch.wdata;
        dqso_pkg::CFG_DISTANCE_SCALE:   regs_nxt.distance_scale = cfg_ch.wdata;
        dqso_pkg::CFG_DIRECTION_INVERT:
          regs_nxt.direction_invert = cfg_ch.wdata[dqso_pkg::INV_W-1:0];
        default: regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.speed_scale      <= dqso_pkg::SPEED_SCALE_RST;
      regs_r.distance_scale   <= dqso_pkg::DISTANCE_SCALE_RST;
      regs_r.direction_invert <= dqso_pkg::DIR_INVERT_RST;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs = regs_r;

endmodule

`default_nettype wire

// ----- rtl/core/dqso_wheel.sv -----
// One wheel's state and datapath: period count, edge total, speed, trip and total distance.
// Depends on dqso_pkg. The state registers double as the result register for the wheel.
`default_nettype none

module dqso_wheel #(
  parameter int COUNT_BITS = dqso_pkg::COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  dqso_pkg::wheel_ctrl_t                 ctrl,
  input  logic        [dqso_pkg::SCALE_W-1:0]   speed_scale,
  input  logic        [dqso_pkg::SCALE_W-1:0]   distance_scale,
  input  logic                                  invert,
  output logic signed [dqso_pkg::SPEED_W-1:0]   speed,
  output logic signed [dqso_pkg::DIST_W-1:0]    trip,
  output logic signed [dqso_pkg::DIST_W-1:0]    total,
  output logic        [dqso_pkg::EDGES_W-1:0]   edges
);

  localparam int SPEED_W = dqso_pkg::SPEED_W;
  localparam int DIST_W  = dqso_pkg::DIST_W;
  localparam int EDGES_W = dqso_pkg::EDGES_W;
  // Product of the signed count and a zero-extended 24-bit scale.
  localparam int PW  = COUNT_BITS + dqso_pkg::SCALE_W + 1;
  localparam int SPW = (PW > SPEED_W) ? PW : SPEED_W + 1;
  localparam int SW  = ((PW > DIST_W) ? PW : DIST_W) + 1;

  localparam logic signed [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};
  localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
  localparam logic signed [COUNT_BITS-1:0] CNT_NEG =
    {1'b1, {(COUNT_BITS-2){1'b0}}, 1'b1};

  localparam logic signed [SPW-1:0] SPD_HI = {{(SPW-SPEED_W+1){1'b0}}, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPW-1:0] SPD_LO = {{(SPW-SPEED_W+1){1'b1}}, {(SPEED_W-1){1'b0}}};
  localparam logic signed [SW-1:0]  DST_HI = {{(SW-DIST_W+1){1'b0}}, {(DIST_W-1){1'b1}}};
  localparam logic signed [SW-1:0]  DST_LO = {{(SW-DIST_W+1){1'b1}}, {(DIST_W-1){1'b0}}};

  localparam logic signed [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic signed [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0]  DIST_MAX  = {1'b0, {(DIST_W-1){1'b1}}};
  localparam logic signed [DIST_W-1:0]  DIST_MIN  = {1'b1, {(DIST_W-1){1'b0}}};

  logic signed [COUNT_BITS-1:0] count_r, count_nxt;
  logic        [EDGES_W-1:0]    edges_r, edges_nxt;
  logic signed [SPEED_W-1:0]    speed_r, speed_nxt;
  logic signed [DIST_W-1:0]     trip_r, trip_nxt;
  logic signed [DIST_W-1:0]     total_r, total_nxt;

  logic signed [PW-1:0]      spd_prod;
  logic signed [PW-1:0]      dst_prod;
  logic signed [SPW-1:0]     spd_ext;
  logic signed [SW-1:0]      trip_sum;
  logic signed [SW-1:0]      total_sum;
  logic signed [SPEED_W-1:0] speed_sat;
  logic signed [DIST_W-1:0]  trip_sat;
  logic signed [DIST_W-1:0]  total_sat;
  logic                      up;

  assign up = ctrl.dir_up ^ invert;

  assign spd_prod  = PW'(count_r) * PW'($signed({1'b0, speed_scale}));
  assign dst_prod  = PW'(count_r) * PW'($signed({1'b0, distance_scale}));
  assign spd_ext   = SPW'(spd_prod);
  assign trip_sum  = SW'(trip_r) + SW'(dst_prod);
  assign total_sum = SW'(total_r) + SW'(dst_prod);

  always_comb begin
    if (spd_ext > SPD_HI) begin
      speed_sat = SPEED_MAX;
    end else if (spd_ext < SPD_LO) begin
      speed_sat = SPEED_MIN;
    end else begin
      speed_sat = spd_ext[SPEED_W-1:0];
    end

    if (trip_sum > DST_HI) begin
      trip_sat = DIST_MAX;
    end else if (trip_sum < DST_LO) begin
      trip_sat = DIST_MIN;
    end else begin
      trip_sat = trip_sum[DIST_W-1:0];
    end

    if (total_sum > DST_HI) begin
      total_sat = DIST_MAX;
    end else if (total_sum < DST_LO) begin
      total_sat = DIST_MIN;
    end else begin
      total_sat = total_sum[DIST_W-1:0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    edges_nxt = edges_r;
    speed_nxt = speed_r;
    trip_nxt  = trip_r;
    total_nxt = total_r;
    if (ctrl.edge_hit) begin
      edges_nxt = edges_r + EDGES_W'(1);
      // The count stops one short of the most negative code, symmetric with the top.
      if (up) begin
        if (count_r != CNT_MAX) count_nxt = count_r + CNT_ONE;
      end else begin
        if (count_r != CNT_NEG) count_nxt = count_r - CNT_ONE;
      end
    end
    if (ctrl.tick) begin
      speed_nxt = speed_sat;
      trip_nxt  = trip_sat;
      total_nxt = total_sat;
      count_nxt = '0;
    end
    if (ctrl.clear) begin
      trip_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      edges_r <= '0;
      speed_r <= '0;
      trip_r  <= '0;
      total_r <= '0;
    end else begin
      count_r <= count_nxt;
      edges_r <= edges_nxt;
      speed_r <= speed_nxt;
      trip_r  <= trip_nxt;
      total_r <= total_nxt;
    end
  end

  assign speed = speed_r;
  assign trip  = trip_r;
  assign total = total_r;
  assign edges = edges_r;

endmodule

`default_nettype wire

// ----- rtl/core/dual_quadrature_speed_odometer.sv -----
// Top level of the two-wheel x4 quadrature odometer: input register, decode, two wheels.
// Depends on dqso_pkg, the three channel interfaces, dqso_cfg and dqso_wheel.
//
//   channel   direction  handshake      carries
//   in_ch     sink       valid/ready    req_type, motor_sel, edge_channel, level_a, level_b
//   out_ch    source     valid/ready    speeds, trip and total distances, edge totals
//   cfg_ch    sink       valid/ready    addr (register index), wdata; ready is always high
//
// Each transaction sits in the input register while the wheel datapath (a count by scale
// multiply and a saturating add) works on it; the wheel state registers, which hold the
// result, load when the result slot is free or being emptied. One transaction is accepted
// per cycle while the result is not stalled. A stalled result holds the wheel state; one more
// transaction waits in the input register. Synchronous active-low reset clears the wheel
// state and loads the register defaults.
`default_nettype none

module dual_quadrature_speed_odometer #(
  parameter int COUNT_BITS = dqso_pkg::COUNT_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dqso_in_if.sink    in_ch,
  dqso_out_if.source out_ch,
  dqso_cfg_if.sink   cfg_ch
);

  dqso_pkg::cfg_regs_t   regs;
  dqso_pkg::wheel_ctrl_t ctrl_left;
  dqso_pkg::wheel_ctrl_t ctrl_right;

  logic                       s1_valid_r, s1_valid_nxt;
  logic [dqso_pkg::REQ_W-1:0] req_r;
  logic                       motor_r;
  logic                       chan_r;
  logic                       la_r;
  logic                       lb_r;
  logic                       out_valid_r, out_valid_nxt;

  logic in_accept;
  logic adv;
  logic is_edge;
  logic is_tick;
  logic is_clear;
  logic dir_up;

  dqso_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  // The held item moves into the wheels when the result slot is free or being emptied.
  assign adv          = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign s1_valid_nxt = in_accept || (s1_valid_r && !adv);
  assign out_valid_nxt = adv || (out_valid_r && !out_ch.ready);

  always_comb begin
    is_edge  = 1'b0;
    is_tick  = 1'b0;
    is_clear = 1'b0;
    case (req_r)
      dqso_pkg::REQ_EDGE:  is_edge  = 1'b1;
      dqso_pkg::REQ_TICK:  is_tick  = 1'b1;
      dqso_pkg::REQ_CLEAR: is_clear = 1'b1;
      default: begin
        is_edge  = 1'b0;
        is_tick  = 1'b0;
        is_clear = 1'b0;
      end
    endcase
  end

  // Forward on an A edge when the levels differ, on a B edge when they match.
  assign dir_up = (chan_r == dqso_pkg::CHAN_A) ? (la_r != lb_r) : (la_r == lb_r);

  always_comb begin
    ctrl_left.edge_hit  = adv && is_edge && (motor_r == dqso_pkg::MOTOR_LEFT);
    ctrl_left.tick      = adv && is_tick;
    ctrl_left.clear     = adv && is_clear;
    ctrl_left.dir_up    = dir_up;
    ctrl_right.edge_hit = adv && is_edge && (motor_r == dqso_pkg::MOTOR_RIGHT);
    ctrl_right.tick     = adv && is_tick;
    ctrl_right.clear    = adv && is_clear;
    ctrl_right.dir_up   = dir_up;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      req_r   <= in_ch.req_type;
      motor_r <= in_ch.motor_sel;
      chan_r  <= in_ch.edge_channel;
      la_r    <= in_ch.level_a;
      lb_r    <= in_ch.level_b;
    end
  end

  dqso_wheel #(
    .COUNT_BITS (COUNT_BITS)
  ) u_wheel_left (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl_left),
    .speed_scale    (regs.speed_scale),
    .distance_scale (regs.distance_scale),
    .invert         (regs.direction_invert[0]),
    .speed          (out_ch.speed_left),
    .trip           (out_ch.trip_left),
    .total          (out_ch.total_left),
    .edges          (out_ch.edges_left)
  );

  dqso_wheel #(
    .COUNT_BITS (COUNT_BITS)
  ) u_wheel_right (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl_right),
    .speed_scale    (regs.speed_scale),
    .distance_scale (regs.distance_scale),
    .invert         (regs.direction_invert[1]),
    .speed          (out_ch.speed_right),
    .trip           (out_ch.trip_right),
    .total          (out_ch.total_right),
    .edges          (out_ch.edges_right)
  );

  assign out_ch.valid = out_valid_r;

endmodule

`default_nettype wire

// ----- test/dual_quadrature_speed_odometer_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the two-wheel quadrature odometer: directed rows, a full-scale
// edge burst and random quadrature traffic, checked against an in-bench predictor or typed readings.
// Depends on dqso_pkg, the three channel interfaces and the dual_quadrature_speed_odometer RTL.

module dual_quadrature_speed_odometer_tb;
  import dqso_pkg::*;

  localparam int CNT_W = COUNT_BITS_DEF;
  localparam int COUNT_LIM = (1 << (CNT_W - 1)) - 1;
  localparam int BURST_EDGES = 24;
  localparam int PHASE_ITEMS = 110;
  localparam int PHASES = 8;
  localparam logic CHAN_B = 1'b1;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef enum int {FLOW_FREE, FLOW_SENDER_GAPS, FLOW_SINK_STALLS, FLOW_BOTH} flow_t;

  typedef struct packed {
    logic signed [SPEED_W-1:0] speed_left;
    logic signed [SPEED_W-1:0] speed_right;
    logic signed [DIST_W-1:0]  trip_left;
    logic signed [DIST_W-1:0]  trip_right;
    logic signed [DIST_W-1:0]  total_left;
    logic signed [DIST_W-1:0]  total_right;
    logic [EDGES_W-1:0]        edges_left;
    logic [EDGES_W-1:0]        edges_right;
  } reading_t;

  typedef struct {
    logic [REQ_W-1:0] req;
    logic             motor;
    logic             chan;
    logic             lvl_a;
    logic             lvl_b;
    bit               typed;
    reading_t         want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;
  flow_t flow;

  dqso_in_if  in_bus();
  dqso_out_if out_bus();
  dqso_cfg_if cfg_bus();

  dual_quadrature_speed_odometer #(.COUNT_BITS(CNT_W)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block: configuration and per-wheel state.
  logic [SCALE_W-1:0] speed_scale_q16 = SPEED_SCALE_RST;
  logic [SCALE_W-1:0] dist_scale_q16  = DISTANCE_SCALE_RST;
  logic [INV_W-1:0]   invert_mask     = DIR_INVERT_RST;
  int                 wheel_count [2] = '{0, 0};
  logic [EDGES_W-1:0] edge_tally  [2] = '{0, 0};
  longint             wheel_speed [2] = '{0, 0};
  longint             wheel_trip  [2] = '{0, 0};
  longint             wheel_total [2] = '{0, 0};

  reading_t  pending_readings [$];
  reading_t  predicted_reading;
  reading_t  oldest_reading;
  plan_row_t directed_plan [$];
  int        fault_count = 0;
  int        result_seq = 0;

  // Travels with the payload so the scoreboard sees the row's hand-typed reading.
  bit       typed_pending;
  reading_t typed_reading;

  function automatic longint clamp_signed(longint v, int bits);
    longint hi;
    longint lo;
    hi = (longint'(1) << (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic reading_t advance_odometer(logic [REQ_W-1:0] req, logic m, logic ch,
                                                logic la, logic lb);
    logic     up;
    longint   inc;
    reading_t r;
    case (req)
      REQ_EDGE: begin
        up = (ch == CHAN_A) ? (la != lb) : (la == lb);
        if (invert_mask[m]) up = !up;
        edge_tally[m] = edge_tally[m] + 1'b1;
        if (up) begin
          if (wheel_count[m] < COUNT_LIM) wheel_count[m]++;
        end else if (wheel_count[m] > -COUNT_LIM) begin
          wheel_count[m]--;
        end
      end
      REQ_TICK: begin
        for (int k = 0; k < 2; k++) begin
          inc = wheel_count[k] * longint'(dist_scale_q16);
          wheel_speed[k] = clamp_signed(wheel_count[k] * longint'(speed_scale_q16), SPEED_W);
          wheel_trip[k]  = clamp_signed(wheel_trip[k] + inc, DIST_W);
          wheel_total[k] = clamp_signed(wheel_total[k] + inc, DIST_W);
          wheel_count[k] = 0;
        end
      end
      REQ_CLEAR: begin
        wheel_trip[0] = 0;
        wheel_trip[1] = 0;
      end
      default: ;
    endcase
    r.speed_left  = SPEED_W'(wheel_speed[0]);
    r.speed_right = SPEED_W'(wheel_speed[1]);
    r.trip_left   = DIST_W'(wheel_trip[0]);
    r.trip_right  = DIST_W'(wheel_trip[1]);
    r.total_left  = DIST_W'(wheel_total[0]);
    r.total_right = DIST_W'(wheel_total[1]);
    r.edges_left  = edge_tally[0];
    r.edges_right = edge_tally[1];
    return r;
  endfunction

  function automatic reading_t make_reading(longint sl, longint sr, longint tl, longint tr,
                                            longint gl, longint gr, longint el, longint er);
    reading_t r;
    r.speed_left  = SPEED_W'(sl);
    r.speed_right = SPEED_W'(sr);
    r.trip_left   = DIST_W'(tl);
    r.trip_right  = DIST_W'(tr);
    r.total_left  = DIST_W'(gl);
    r.total_right = DIST_W'(gr);
    r.edges_left  = EDGES_W'(el);
    r.edges_right = EDGES_W'(er);
    return r;
  endfunction

  function automatic void plan_add(logic [REQ_W-1:0] req, logic m, logic ch, logic la,
                                   logic lb, bit typed, reading_t want);
    directed_plan.push_back('{req, m, ch, la, lb, typed, want});
  endfunction

  task automatic compare_field(string name, logic signed [63:0] want,
                               logic signed [63:0] got);
    if (want !== got) begin
      fault_count++;
      if (fault_count <= 10)
        $display("wrong %s in result %0d: expected %0d, got %0d", name, result_seq, want, got);
    end
  endtask

  function automatic bit sender_idles();
    case (flow)
      FLOW_SENDER_GAPS: return $urandom_range(99) < 63;
      FLOW_BOTH:        return $urandom_range(99) < 17;
      default:          return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin
    case (flow)
      FLOW_SINK_STALLS: out_bus.ready <= $urandom_range(99) >= 63;
      FLOW_BOTH:        out_bus.ready <= $urandom_range(99) >= 17;
      default:          out_bus.ready <= 1'b1;
    endcase
  end

  // Scoreboard: tracks register writes, predicts every accepted request, checks every result.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_bus.addr)
          CFG_SPEED_SCALE:      speed_scale_q16 = cfg_bus.wdata[SCALE_W-1:0];
          CFG_DISTANCE_SCALE:   dist_scale_q16  = cfg_bus.wdata[SCALE_W-1:0];
          CFG_DIRECTION_INVERT: invert_mask     = cfg_bus.wdata[INV_W-1:0];
          default: ;
        endcase
      end
      if (out_bus.valid && out_bus.ready) begin
        if (pending_readings.size() == 0) begin
          fault_count++;
          if (fault_count <= 10) $display("result %0d arrived with none pending", result_seq);
        end else begin
          oldest_reading = pending_readings.pop_front();
          compare_field("speed_left", oldest_reading.speed_left, out_bus.speed_left);
          compare_field("speed_right", oldest_reading.speed_right, out_bus.speed_right);
          compare_field("trip_left", oldest_reading.trip_left, out_bus.trip_left);
          compare_field("trip_right", oldest_reading.trip_right, out_bus.trip_right);
          compare_field("total_left", oldest_reading.total_left, out_bus.total_left);
          compare_field("total_right", oldest_reading.total_right, out_bus.total_right);
          compare_field("edges_left", oldest_reading.edges_left, out_bus.edges_left);
          compare_field("edges_right", oldest_reading.edges_right, out_bus.edges_right);
        end
        result_seq++;
      end
      if (in_bus.valid && in_bus.ready) begin
        predicted_reading = advance_odometer(in_bus.req_type, in_bus.motor_sel,
                                             in_bus.edge_channel, in_bus.level_a,
                                             in_bus.level_b);
        pending_readings.push_back(typed_pending ? typed_reading : predicted_reading);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the transaction was accepted,
  // leaving valid high so back-to-back requests need no extra assignment.
  task automatic send_request(logic [REQ_W-1:0] req, logic m, logic ch, logic la, logic lb,
                              bit typed, reading_t want);
    while (sender_idles()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.req_type     <= req;
    in_bus.motor_sel    <= m;
    in_bus.edge_channel <= ch;
    in_bus.level_a      <= la;
    in_bus.level_b      <= lb;
    typed_pending       <= typed;
    typed_reading       <= want;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_registers(logic [CFG_DAT_W-1:0] spd, logic [CFG_DAT_W-1:0] dst,
                                   logic [CFG_DAT_W-1:0] inv, bit poke_unused);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_DAT_W-1:0] dat [4];
    int                   n;
    idx = '{CFG_SPEED_SCALE, CFG_DISTANCE_SCALE, CFG_DIRECTION_INVERT,
            CFG_IDX_W'($urandom_range(255, 3))};
    dat = '{spd, dst, inv, CFG_DAT_W'($urandom)};
    n = poke_unused ? 4 : 3;
    drain_results();
    for (int i = 0; i < n; i++) begin
      cfg_bus.valid <= 1'b1;
      cfg_bus.addr  <= idx[i];
      cfg_bus.wdata <= dat[i];
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("dual_quadrature_speed_odometer: mismatch");
    $finish;
  end

  initial begin
    logic [1:0] quad_pos [2];
    bit         quad_fwd [2];
    logic [1:0] prior;
    logic       m;
    logic       la;
    int         roll;

    rst_n               = 1'b0;
    flow                = FLOW_FREE;
    in_bus.valid        = 1'b0;
    in_bus.req_type     = REQ_EDGE;
    in_bus.motor_sel    = MOTOR_LEFT;
    in_bus.edge_channel = CHAN_A;
    in_bus.level_a      = 1'b0;
    in_bus.level_b      = 1'b0;
    out_bus.ready       = 1'b0;
    cfg_bus.valid       = 1'b0;
    cfg_bus.addr        = CFG_SPEED_SCALE;
    cfg_bus.wdata       = '0;
    typed_pending       = 1'b0;
    typed_reading       = '0;
    quad_pos            = '{2'd0, 2'd0};
    quad_fwd            = '{1'b1, 1'b0};

    // Directed rows run on the reset configuration: left wheel normal, right wheel mirrored.
    plan_add(REQ_TICK, MOTOR_LEFT, CHAN_A, 1'b0, 1'b0, 1'b1, '0);
    plan_add(REQ_UNUSED, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b1, 1'b1, '0);
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_A, 1'b1, 1'b0, 1'b1, make_reading(0, 0, 0, 0, 0, 0, 1, 0));
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b1, 1'b1,
             make_reading(0, 0, 0, 0, 0, 0, 1, 1));
    plan_add(REQ_TICK, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b1, 1'b1,
             make_reading(63350, -63350, 634, -634, 634, -634, 1, 1));
    plan_add(REQ_CLEAR, MOTOR_RIGHT, CHAN_B, 1'b0, 1'b1, 1'b1,
             make_reading(63350, -63350, 0, 0, 634, -634, 1, 1));
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_A, 1'b0, 1'b0, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_A, 1'b0, 1'b1, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_B, 1'b1, 1'b0, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_B, 1'b1, 1'b1, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_A, 1'b1, 1'b1, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_A, 1'b1, 1'b0, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_B, 1'b0, 1'b1, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_B, 1'b0, 1'b0, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_LEFT, CHAN_A, 1'b1, 1'b0, 1'b0, '0);
    plan_add(REQ_EDGE, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b0, 1'b0, '0);
    plan_add(REQ_TICK, MOTOR_LEFT, CHAN_A, 1'b0, 1'b1, 1'b0, '0);
    plan_add(REQ_CLEAR, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b0, 1'b0, '0);
    plan_add(REQ_UNUSED, MOTOR_RIGHT, CHAN_B, 1'b1, 1'b1, 1'b0, '0);
    plan_add(REQ_TICK, MOTOR_RIGHT, CHAN_A, 1'b1, 1'b1, 1'b0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_plan[i])
      send_request(directed_plan[i].req, directed_plan[i].motor, directed_plan[i].chan,
                   directed_plan[i].lvl_a, directed_plan[i].lvl_b, directed_plan[i].typed,
                   directed_plan[i].want);

    // Full-scale registers, no inversion (upper data bits must be dropped), then walk the
    // left count up and the right count down before a tick with the widest scales.
    program_registers(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFC, 1'b0);
    for (int i = 0; i < BURST_EDGES; i++) begin
      send_request(REQ_EDGE, MOTOR_LEFT, CHAN_A, i[0], !i[0], 1'b0, '0);
      send_request(REQ_EDGE, MOTOR_RIGHT, CHAN_B, i[0], !i[0], 1'b0, '0);
    end
    send_request(REQ_TICK, MOTOR_LEFT, CHAN_A, 1'b0, 1'b0, 1'b0, '0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       program_registers(SPEED_SCALE_RST, DISTANCE_SCALE_RST, DIR_INVERT_RST, 1'b0);
        1:       program_registers(24'hFFFFFF, 24'hFFFFFF, 24'd3, 1'b0);
        2:       program_registers(24'd0, 24'd0, 24'd0, 1'b0);
        5:       program_registers(24'd1, 24'd1, 24'd1, 1'b0);
        default: program_registers(24'($urandom), 24'($urandom), 24'($urandom), p == 3);
      endcase
      flow = flow_t'(p % 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // Halfway through a gapped phase, hold off until the block has emptied.
        if (p == 1 && n == PHASE_ITEMS / 2) drain_results();
        roll = $urandom_range(99);
        if (roll < 8) begin
          send_request(REQ_W'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'($urandom), 1'b0, '0);
        end else if (roll < 17) begin
          send_request(REQ_TICK, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'b0, '0);
        end else if (roll < 19) begin
          send_request(REQ_CLEAR, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'b0, '0);
        end else if (roll < 20) begin
          send_request(REQ_UNUSED, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                       1'b0, '0);
        end else begin
          // Legal quadrature step: Gray-code walk with an occasional direction reversal.
          m = 1'($urandom);
          if ($urandom_range(7) == 0) quad_fwd[m] = !quad_fwd[m];
          prior = quad_pos[m];
          quad_pos[m] = quad_fwd[m] ? prior + 2'd1 : prior - 2'd1;
          la = quad_pos[m][1];
          send_request(REQ_EDGE, m, (la != prior[1]) ? CHAN_A : CHAN_B, la,
                       quad_pos[m][1] ^ quad_pos[m][0], 1'b0, '0);
        end
      end
    end

    drain_results();
    if (fault_count == 0 && pending_readings.size() == 0)
      $display("dual_quadrature_speed_odometer: match");
    else
      $display("dual_quadrature_speed_odometer: mismatch");
    $finish;
  end

endmodule
